// ----- rtl/avt_pkg.sv -----
// Shared types and constants for the affine vertex transform.
package avt_pkg;

   localparam int COEF_W = 32;
   localparam int VEC_W = 33;
   localparam int PROD_W = COEF_W + VEC_W;
   localparam int SUM_W = PROD_W + 2;
   localparam int RES_W = SUM_W + 1;
   localparam int NCOEF = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] MODE_LOAD = 3'd0;
   localparam logic [2:0] MODE_ROT = 3'd1;
   localparam logic [2:0] MODE_ROT_TRANS = 3'd2;
   localparam logic [2:0] MODE_TROT = 3'd3;
   localparam logic [2:0] MODE_UNTRANS_TROT = 3'd4;

   localparam logic [3:0] LAST_SLOT = 4'd11;

   typedef struct packed {
      logic is_load;
      logic transpose;
      logic add_t;
      logic sub_t;
      logic [3:0] index;
      logic signed [COEF_W-1:0] x;
      logic signed [COEF_W-1:0] y;
      logic signed [COEF_W-1:0] z;
   } entry_type;

endpackage

// ----- rtl/avt_front.sv -----
// Front end: decodes an incoming transaction into a queue entry or drops it.
module avt_front (
   input  logic [2:0] req_mode,
   input  logic [3:0] req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   output logic keep,
   output avt_pkg::entry_type entry
);
   import avt_pkg::*;

   logic is_load;
   logic is_vec;

   always_comb begin
      is_load = (req_mode == MODE_LOAD);
      is_vec = req_mode inside {[MODE_ROT:MODE_UNTRANS_TROT]};
      keep = (is_load && (req_coef_index <= LAST_SLOT)) || is_vec;
      entry.is_load = is_load;
      entry.transpose = req_mode inside {MODE_TROT, MODE_UNTRANS_TROT};
      entry.add_t = (req_mode == MODE_ROT_TRANS);
      entry.sub_t = (req_mode == MODE_UNTRANS_TROT);
      entry.index = req_coef_index;
      entry.x = is_load ? req_coef_value : req_vec_x;
      entry.y = req_vec_y;
      entry.z = req_vec_z;
   end

endmodule

// ----- rtl/avt_queue.sv -----
// Short FIFO between the front end and the transform pipeline.
module avt_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  avt_pkg::entry_type push_entry,
   input  logic pop,
   output avt_pkg::entry_type head,
   output logic empty,
   output logic full
);
   import avt_pkg::*;

   entry_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0] count_ff, count_in;

   always_comb begin
      empty = (count_ff == '0);
      full = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      head = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/avt_back.sv -----
// Back end: coefficient store and the pipelined 3x3 multiply, translation, shift and clip.
module avt_back #(
   parameter int FRAC_BITS = 16,
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  avt_pkg::entry_type head,
   input  logic q_empty,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic rsp_saturated
);
   import avt_pkg::*;

   localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;
   localparam logic signed [RES_W-1:0] RES_MAX =
      {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;

   logic adv;
   logic signed [COEF_W-1:0] m_ff [NCOEF];

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   logic a_valid_in;

   logic signed [VEC_W-1:0] va_ff [3], va_in [3];
   logic signed [COEF_W-1:0] cf_ff [9], cf_in [9];
   logic signed [COEF_W-1:0] ta_ff [3], tb_ff [3], tc_ff [3];
   logic adda_ff, addb_ff, addc_ff;
   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [RES_W-1:0] res_ff [3], res_in [3];
   logic signed [COORD_WIDTH-1:0] clip_v [3];
   logic sat_in;
   logic signed [31:0] out_ff [3];
   logic sat_ff;
   logic signed [COEF_W-1:0] src [3];

   always_comb begin
      adv = !rsp_valid_ff || !rsp_stall;
      pop = adv && !q_empty;
      a_valid_in = pop && !head.is_load;
      src[0] = head.x;
      src[1] = head.y;
      src[2] = head.z;
      for (int r = 0; r < 3; r++) begin
         va_in[r] = head.sub_t ? VEC_W'(src[r]) - VEC_W'(m_ff[r*4+3]) : VEC_W'(src[r]);
         for (int c = 0; c < 3; c++) begin
            cf_in[r*3+c] = head.transpose ? m_ff[c*4+r] : m_ff[r*4+c];
         end
      end
      sat_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         res_in[r] = RES_W'(sum_ff[r] >>> FRAC_BITS) + (addc_ff ? RES_W'(tc_ff[r]) : '0);
         if (res_ff[r] > RES_MAX) begin
            clip_v[r] = RES_MAX[COORD_WIDTH-1:0];
            sat_in = 1'b1;
         end else if (res_ff[r] < RES_MIN) begin
            clip_v[r] = RES_MIN[COORD_WIDTH-1:0];
            sat_in = 1'b1;
         end else begin
            clip_v[r] = res_ff[r][COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCOEF; i++) begin
            m_ff[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
         end
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         if (pop && head.is_load) begin
            m_ff[head.index] <= head.x;
         end
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            va_ff[r] <= va_in[r];
            ta_ff[r] <= m_ff[r*4+3];
            tb_ff[r] <= ta_ff[r];
            tc_ff[r] <= tb_ff[r];
            sum_ff[r] <= SUM_W'(prod_ff[r*3]) + SUM_W'(prod_ff[r*3+1])
                       + SUM_W'(prod_ff[r*3+2]);
            res_ff[r] <= res_in[r];
            out_ff[r] <= 32'(clip_v[r]);
         end
         for (int k = 0; k < 9; k++) begin
            cf_ff[k] <= cf_in[k];
            prod_ff[k] <= PROD_W'(va_ff[k % 3]) * PROD_W'(cf_ff[k]);
         end
         adda_ff <= head.add_t;
         addb_ff <= adda_ff;
         addc_ff <= addb_ff;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

// ----- rtl/affine_vertex_transform.sv -----
// Affine 3x4 vertex transform: decode front end, queue, pipelined transform back end.
//
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_mode, req_coef_index, req_coef_value, req_vec_x/y/z
// rsp      out  rsp_valid/rsp_stall  rsp_out_x/y/z, rsp_saturated
//
// One transaction per cycle sustained while rsp_stall is low; vectors pass queue, then back end.
// Loads and unused modes produce no result; loads update the matrix in queue order.
// Reset loads identity rotation and zero translation and empties the queue.
// A stalled result freezes the back-end pipeline; req_stall rises only when the 4-entry
// queue is full.
module affine_vertex_transform #(
   parameter int FRAC_BITS = 16,
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_mode,
   input  logic [3:0] req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic rsp_saturated
);
   import avt_pkg::*;

   logic keep;
   logic push;
   logic pop;
   logic q_empty;
   logic q_full;
   entry_type front_entry;
   entry_type head;

   avt_front u_front (
      .req_mode(req_mode),
      .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value),
      .req_vec_x(req_vec_x),
      .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z),
      .keep(keep),
      .entry(front_entry)
   );

   assign req_stall = q_full;
   assign push = req_valid && !q_full && keep;

   avt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(front_entry),
      .pop(pop),
      .head(head),
      .empty(q_empty),
      .full(q_full)
   );

   avt_back #(
      .FRAC_BITS(FRAC_BITS),
      .COORD_WIDTH(COORD_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .q_empty(q_empty),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_saturated(rsp_saturated)
   );

endmodule
